// File: hw/rtl/i2cag_pkg.sv
// Package for the im2col address generator: limits, field widths,
// register codes and the structs passed between the front, queue and back.
// No dependencies.
package i2cag_pkg;

    localparam int MAX_SIDE     = 512;
    localparam int MAX_CHANNELS = 1024;
    localparam int MAX_KERNEL   = 7;
    localparam int STEP_LIMIT   = 8;

    localparam int CH_W     = 11;  // num_channels register
    localparam int SIDE_W   = 10;  // image height / width registers
    localparam int KER_W    = 3;
    localparam int STEP_W   = 4;
    localparam int PAD_W    = 2;
    localparam int IDX_W    = 34;
    localparam int CHAN_W   = 10;
    localparam int POS_W    = 11;  // signed source row / column
    localparam int ADDR_W   = 28;
    localparam int SPAN_W   = 11;  // padded side, holds up to MAX_SIDE + 6
    localparam int HC_W     = 20;  // height * channel
    localparam int LIN_W    = 21;  // height * channel + row
    localparam int PROD_W   = 31;  // width * (height * channel + row)

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_CHANNELS = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_KERNEL_SIZE  = 3'd3,
        REG_STEP_SIZE    = 3'd4,
        REG_BORDER_PAD   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0]   num_channels;
        logic [SIDE_W-1:0] image_height;
        logic [SIDE_W-1:0] image_width;
        logic [KER_W-1:0]  kernel_size;
        logic [STEP_W-1:0] step_size;
        logic [PAD_W-1:0]  border_pad;
    } cfg_t;

    // one walk position, as handed from the front to the back
    typedef struct packed {
        logic              no_work;
        logic              last;
        logic [CHAN_W-1:0] chan;
        logic [KER_W-1:0]  kr;
        logic [KER_W-1:0]  kc;
        logic [SIDE_W-1:0] hs;    // output row times stride
        logic [SIDE_W-1:0] ws;    // output column times stride
        logic [IDX_W-1:0]  idx;
    } desc_t;

endpackage

// File: hw/rtl/i2cag_if.sv
// Handshake channels of the im2col address generator: the tick word in and
// the element word out. Depends on i2cag_pkg.
interface i2cag_cmd_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface i2cag_elem_if import i2cag_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         column_index;
    logic [CHAN_W-1:0]        source_channel;
    logic signed [POS_W-1:0]  source_row;
    logic signed [POS_W-1:0]  source_col;
    logic [ADDR_W-1:0]        image_address;
    logic                     is_padding;
    logic                     last;
    logic                     no_work;

    modport source (output valid, output column_index, output source_channel,
                    output source_row, output source_col, output image_address,
                    output is_padding, output last, output no_work, input ready);
    modport sink   (input valid, input column_index, input source_channel,
                    input source_row, input source_col, input image_address,
                    input is_padding, input last, input no_work, output ready);
endinterface

// File: hw/rtl/im2col_address_generator_unit.sv
// im2col address generator, top level.
// A tick word accepted is queued, then passes the back's stage 1 and output registers.
// Throughput: one word per cycle while the queue is not full, set by the walk counter
// update in the front; a stalled output backs up into a two-entry descriptor queue.
// Reset: registers go to 1,1,1,1,1,0; walk at its first element; queue and pipe empty.
// Depends on i2cag_pkg, i2cag_if, i2cag_cfg, i2cag_front, i2cag_fifo, i2cag_back.
module im2col_address_generator_unit import i2cag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    i2cag_cmd_if.sink             cmd,
    i2cag_elem_if.source          elem
);

    cfg_t  cfg;
    logic  rewind;
    logic  push, pop, full, empty;
    desc_t push_desc, head;

    i2cag_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .rewind    (rewind)
    );

    i2cag_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rewind    (rewind),
        .cmd       (cmd),
        .fifo_full (full),
        .push      (push),
        .push_desc (push_desc)
    );

    i2cag_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    i2cag_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fifo_empty (empty),
        .head       (head),
        .pop        (pop),
        .elem       (elem)
    );

endmodule

// File: hw/rtl/i2cag_cfg.sv
// Configuration registers with saturation into the legal ranges.
// Any write to a listed register pulses rewind. Depends on i2cag_pkg.
module i2cag_cfg import i2cag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic                  rewind
);

    cfg_t cfg_reg, cfg_next;

    logic [SIDE_W-1:0] side_val;
    logic [SIDE_W-1:0] side_sat;

    // height and width share one saturation
    assign side_val = cfg_data[SIDE_W-1:0];
    assign side_sat = (side_val == '0) ? SIDE_W'(1) :
                      (side_val > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_val;

    always_comb
    begin
        cfg_next = cfg_reg;
        rewind   = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_NUM_CHANNELS:
                begin
                    rewind = 1'b1;
                    if (cfg_data == '0)
                        cfg_next.num_channels = CH_W'(1);
                    else if (cfg_data > CFG_DATA_W'(MAX_CHANNELS))
                        cfg_next.num_channels = CH_W'(MAX_CHANNELS);
                    else
                        cfg_next.num_channels = cfg_data;
                end
                REG_IMAGE_HEIGHT:
                begin
                    rewind = 1'b1;
                    cfg_next.image_height = side_sat;
                end
                REG_IMAGE_WIDTH:
                begin
                    rewind = 1'b1;
                    cfg_next.image_width = side_sat;
                end
                REG_KERNEL_SIZE:
                begin
                    rewind = 1'b1;
                    if (cfg_data[KER_W-1:0] == '0)
                        cfg_next.kernel_size = KER_W'(1);
                    else if (cfg_data[KER_W-1:0] > KER_W'(MAX_KERNEL))
                        cfg_next.kernel_size = KER_W'(MAX_KERNEL);
                    else
                        cfg_next.kernel_size = cfg_data[KER_W-1:0];
                end
                REG_STEP_SIZE:
                begin
                    rewind = 1'b1;
                    if (cfg_data[STEP_W-1:0] == '0)
                        cfg_next.step_size = STEP_W'(1);
                    else if (cfg_data[STEP_W-1:0] > STEP_W'(STEP_LIMIT))
                        cfg_next.step_size = STEP_W'(STEP_LIMIT);
                    else
                        cfg_next.step_size = cfg_data[STEP_W-1:0];
                end
                REG_BORDER_PAD:
                begin
                    rewind = 1'b1;
                    cfg_next.border_pad = cfg_data[PAD_W-1:0];
                end
                default:
                begin
                    rewind = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_channels <= CH_W'(1);
            cfg_reg.image_height <= SIDE_W'(1);
            cfg_reg.image_width  <= SIDE_W'(1);
            cfg_reg.kernel_size  <= KER_W'(1);
            cfg_reg.step_size    <= STEP_W'(1);
            cfg_reg.border_pad   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/i2cag_front.sv
// Front end: accepts tick words, keeps the walk counters and classifies each
// position (normal, last, no work) into a descriptor. Depends on i2cag_pkg, i2cag_if.
module i2cag_front import i2cag_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          rewind,
    i2cag_cmd_if.sink     cmd,
    input  logic          fifo_full,
    output logic          push,
    output desc_t         push_desc
);

    localparam int KW1 = KER_W + 1;

    logic [KER_W-1:0]  kc_reg, kc_next, kr_reg, kr_next;
    logic [CHAN_W-1:0] ch_reg, ch_next;
    logic [SIDE_W-1:0] hs_reg, hs_next, ws_reg, ws_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic [KER_W-1:0]  kc_c, kr_c;
    logic [CHAN_W-1:0] ch_c;
    logic [SIDE_W-1:0] hs_c, ws_c;
    logic [IDX_W-1:0]  idx_c;

    logic [SPAN_W-1:0] ph, pw, kx, row_lim, col_lim;
    logic              no_work;
    logic              col_more, row_more, kc_more, kr_more, ch_more, last;

    always_comb
    begin
        kx      = SPAN_W'(cfg.kernel_size);
        ph      = SPAN_W'(cfg.image_height) + SPAN_W'({cfg.border_pad, 1'b0});
        pw      = SPAN_W'(cfg.image_width) + SPAN_W'({cfg.border_pad, 1'b0});
        no_work = (ph < kx) || (pw < kx);
        row_lim = ph - kx;
        col_lim = pw - kx;

        // restart rewinds before this word is produced
        kc_c  = cmd.restart ? '0 : kc_reg;
        kr_c  = cmd.restart ? '0 : kr_reg;
        ch_c  = cmd.restart ? '0 : ch_reg;
        hs_c  = cmd.restart ? '0 : hs_reg;
        ws_c  = cmd.restart ? '0 : ws_reg;
        idx_c = cmd.restart ? '0 : idx_reg;

        // next output position still fits in the padded image
        col_more = (SPAN_W'(ws_c) + SPAN_W'(cfg.step_size)) <= col_lim;
        row_more = (SPAN_W'(hs_c) + SPAN_W'(cfg.step_size)) <= row_lim;
        kc_more  = (KW1'(kc_c) + KW1'(1)) < KW1'(cfg.kernel_size);
        kr_more  = (KW1'(kr_c) + KW1'(1)) < KW1'(cfg.kernel_size);
        ch_more  = (CH_W'(ch_c) + CH_W'(1)) < cfg.num_channels;
        last     = !col_more && !row_more && !kc_more && !kr_more && !ch_more;

        cmd.ready = !fifo_full;
        push      = cmd.valid && !fifo_full;

        push_desc = '0;
        if (no_work)
        begin
            push_desc.no_work = 1'b1;
        end
        else
        begin
            push_desc.last = last;
            push_desc.chan = ch_c;
            push_desc.kr   = kr_c;
            push_desc.kc   = kc_c;
            push_desc.hs   = hs_c;
            push_desc.ws   = ws_c;
            push_desc.idx  = idx_c;
        end

        kc_next  = kc_reg;
        kr_next  = kr_reg;
        ch_next  = ch_reg;
        hs_next  = hs_reg;
        ws_next  = ws_reg;
        idx_next = idx_reg;
        if (rewind)
        begin
            kc_next  = '0;
            kr_next  = '0;
            ch_next  = '0;
            hs_next  = '0;
            ws_next  = '0;
            idx_next = '0;
        end
        else if (push)
        begin
            kc_next  = kc_c;
            kr_next  = kr_c;
            ch_next  = ch_c;
            hs_next  = hs_c;
            ws_next  = ws_c;
            idx_next = idx_c;
            if (!no_work)
            begin
                if (last)
                begin
                    kc_next  = '0;
                    kr_next  = '0;
                    ch_next  = '0;
                    hs_next  = '0;
                    ws_next  = '0;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_c + IDX_W'(1);
                    // carry chain: out col, out row, kernel col, kernel row, channel
                    priority if (col_more)
                    begin
                        ws_next = ws_c + SIDE_W'(cfg.step_size);
                    end
                    else if (row_more)
                    begin
                        ws_next = '0;
                        hs_next = hs_c + SIDE_W'(cfg.step_size);
                    end
                    else if (kc_more)
                    begin
                        ws_next = '0;
                        hs_next = '0;
                        kc_next = kc_c + KER_W'(1);
                    end
                    else if (kr_more)
                    begin
                        ws_next = '0;
                        hs_next = '0;
                        kc_next = '0;
                        kr_next = kr_c + KER_W'(1);
                    end
                    else
                    begin
                        ws_next = '0;
                        hs_next = '0;
                        kc_next = '0;
                        kr_next = '0;
                        ch_next = ch_c + CHAN_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg  <= '0;
            kr_reg  <= '0;
            ch_reg  <= '0;
            hs_reg  <= '0;
            ws_reg  <= '0;
            idx_reg <= '0;
        end
        else
        begin
            kc_reg  <= kc_next;
            kr_reg  <= kr_next;
            ch_reg  <= ch_next;
            hs_reg  <= hs_next;
            ws_reg  <= ws_next;
            idx_reg <= idx_next;
        end
    end

    a_kc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        kc_reg < cfg.kernel_size)
        else $error("kernel column counter out of range");

    a_kr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        kr_reg < cfg.kernel_size)
        else $error("kernel row counter out of range");

    a_ch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CH_W'(ch_reg) < cfg.num_channels)
        else $error("channel counter out of range");

endmodule

// File: hw/rtl/i2cag_fifo.sv
// Short descriptor queue between the front and the back.
// Depends on i2cag_pkg.
module i2cag_fifo import i2cag_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t head,
    output logic  full,
    output logic  empty
);

    desc_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + FIFO_PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + FIFO_PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("descriptor queue underflow");

endmodule

// File: hw/rtl/i2cag_back.sv
// Back end: turns descriptors into source position, padding flag and image
// address over two register stages. Depends on i2cag_pkg, i2cag_if.
module i2cag_back import i2cag_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         fifo_empty,
    input  desc_t        head,
    output logic         pop,
    i2cag_elem_if.source elem
);

    logic adv;

    // stage 1
    logic                     s1_v_reg;
    desc_t                    s1_desc_reg;
    logic signed [POS_W-1:0]  s1_row_reg, s1_col_reg;
    logic                     s1_pad_reg;
    logic [HC_W-1:0]          s1_hc_reg;

    logic signed [POS_W-1:0]  row_w, col_w;
    logic                     pad_w;
    logic [HC_W-1:0]          hc_w;

    // output word
    logic                     out_v_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [CHAN_W-1:0]        chan_reg;
    logic signed [POS_W-1:0]  row_reg, col_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic                     pad_reg, last_reg, nw_reg;

    logic [LIN_W-1:0]         lin_w;
    logic [PROD_W-1:0]        prod_w;
    logic [ADDR_W-1:0]        addr_w;

    assign adv = !out_v_reg || elem.ready;
    assign pop = adv && !fifo_empty;

    always_comb
    begin
        if (head.no_work)
        begin
            row_w = '0;
            col_w = '0;
        end
        else
        begin
            row_w = $signed(POS_W'(head.hs) + POS_W'(head.kr) - POS_W'(cfg.border_pad));
            col_w = $signed(POS_W'(head.ws) + POS_W'(head.kc) - POS_W'(cfg.border_pad));
        end
        pad_w = row_w[POS_W-1] || col_w[POS_W-1] ||
                (row_w[SIDE_W-1:0] >= cfg.image_height) ||
                (col_w[SIDE_W-1:0] >= cfg.image_width);
        hc_w  = HC_W'(cfg.image_height) * HC_W'(head.chan);
    end

    always_comb
    begin
        lin_w  = LIN_W'(s1_hc_reg) + LIN_W'(s1_row_reg[SIDE_W-1:0]);
        prod_w = PROD_W'(cfg.image_width) * PROD_W'(lin_w)
                 + PROD_W'(s1_col_reg[SIDE_W-1:0]);
        addr_w = s1_pad_reg ? '0 : prod_w[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= !fifo_empty;
            out_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_desc_reg <= head;
            s1_row_reg  <= row_w;
            s1_col_reg  <= col_w;
            s1_pad_reg  <= pad_w;
            s1_hc_reg   <= hc_w;
            idx_reg     <= s1_desc_reg.idx;
            chan_reg    <= s1_desc_reg.chan;
            row_reg     <= s1_row_reg;
            col_reg     <= s1_col_reg;
            addr_reg    <= addr_w;
            pad_reg     <= s1_pad_reg;
            last_reg    <= s1_desc_reg.last;
            nw_reg      <= s1_desc_reg.no_work;
        end
    end

    assign elem.valid          = out_v_reg;
    assign elem.column_index   = idx_reg;
    assign elem.source_channel = chan_reg;
    assign elem.source_row     = row_reg;
    assign elem.source_col     = col_reg;
    assign elem.image_address  = addr_reg;
    assign elem.is_padding     = pad_reg;
    assign elem.last           = last_reg;
    assign elem.no_work        = nw_reg;

    a_pad_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        elem.valid && elem.is_padding |-> elem.image_address == '0)
        else $error("padding word with nonzero address");

    a_no_work_clean: assert property (@(posedge clk) disable iff (!rst_n)
        elem.valid && elem.no_work |->
            elem.column_index == '0 && !elem.last && !elem.is_padding &&
            elem.image_address == '0 && elem.source_row == '0)
        else $error("no-work word carries data");

    a_inside_image: assert property (@(posedge clk) disable iff (!rst_n)
        elem.valid && !elem.is_padding && !elem.no_work |->
            !elem.source_row[POS_W-1] && !elem.source_col[POS_W-1])
        else $error("non-padding word with negative position");

endmodule

// File: dv/tb_im2col_address_generator_unit.sv
`timescale 1ns / 1ps
// Testbench for im2col_address_generator_unit: random tick words against a walk predictor,
// with random config phases, idling on both handshakes and a long output hold-off.
// Depends on i2cag_pkg, i2cag_if and the RTL of the unit.
module tb_im2col_address_generator_unit;
    import i2cag_pkg::*;

    localparam int RANDOM_TICKS = 1550;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 700;

    // indexes past the register map, which the unit must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]        column_index;
        logic [CHAN_W-1:0]       source_channel;
        logic signed [POS_W-1:0] source_row;
        logic signed [POS_W-1:0] source_col;
        logic [ADDR_W-1:0]       image_address;
        logic                    is_padding;
        logic                    last;
        logic                    no_work;
    } elem_word_t;

    class im2col_walk_model;
        int unsigned channels, height, width, ksize, step, pad;
        int unsigned kc, kr, chan, out_row, out_col;
        logic [IDX_W-1:0] next_index;
        elem_word_t expected_elems[$];
        int errors;
        int checked;

        function new();
            channels = 1;
            height   = 1;
            width    = 1;
            ksize    = 1;
            step     = 1;
            pad      = 0;
            errors   = 0;
            checked  = 0;
            restart_walk();
        endfunction

        function void restart_walk();
            kc = 0;
            kr = 0;
            chan = 0;
            out_row = 0;
            out_col = 0;
            next_index = '0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_NUM_CHANNELS: channels = clamp(data, 1, MAX_CHANNELS);
                REG_IMAGE_HEIGHT: height   = clamp(data[SIDE_W-1:0], 1, MAX_SIDE);
                REG_IMAGE_WIDTH:  width    = clamp(data[SIDE_W-1:0], 1, MAX_SIDE);
                REG_KERNEL_SIZE:  ksize    = clamp(data[KER_W-1:0], 1, MAX_KERNEL);
                REG_STEP_SIZE:    step     = clamp(data[STEP_W-1:0], 1, STEP_LIMIT);
                REG_BORDER_PAD:   pad      = data[PAD_W-1:0];
                default:          return;
            endcase
            restart_walk();
        endfunction

        function void note_tick(logic restart);
            elem_word_t w;
            int unsigned ph, pw, oh, ow;
            int row, col;
            bit at_end;
            w = '0;
            if (restart)
                restart_walk();
            ph = height + 2 * pad;
            pw = width + 2 * pad;
            if (ph < ksize || pw < ksize)
            begin
                // kernel does not fit: flag only, walk holds still
                w.no_work = 1'b1;
                expected_elems.push_back(w);
                return;
            end
            oh = (ph - ksize) / step + 1;
            ow = (pw - ksize) / step + 1;
            row = int'(kr + out_row * step) - int'(pad);
            col = int'(kc + out_col * step) - int'(pad);
            w.column_index   = next_index;
            w.source_channel = chan[CHAN_W-1:0];
            w.source_row     = row[POS_W-1:0];
            w.source_col     = col[POS_W-1:0];
            w.is_padding     = row < 0 || col < 0 || row >= int'(height) || col >= int'(width);
            if (!w.is_padding)
                w.image_address = ADDR_W'(longint'(col) + longint'(width) *
                                  (longint'(row) + longint'(height) * longint'(chan)));
            at_end = out_col + 1 >= ow && out_row + 1 >= oh && kc + 1 >= ksize &&
                     kr + 1 >= ksize && chan + 1 >= channels;
            w.last = at_end;
            expected_elems.push_back(w);
            if (at_end)
            begin
                restart_walk();
                return;
            end
            next_index = next_index + 1'b1;
            out_col++;
            if (out_col >= ow)
            begin
                out_col = 0;
                out_row++;
                if (out_row >= oh)
                begin
                    out_row = 0;
                    kc++;
                    if (kc >= ksize)
                    begin
                        kc = 0;
                        kr++;
                        if (kr >= ksize)
                        begin
                            kr = 0;
                            chan++;
                            if (chan >= channels)
                                chan = 0;
                        end
                    end
                end
            end
        endfunction

        function void compare(string name, logic signed [63:0] want, logic signed [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_element(elem_word_t got);
            elem_word_t want;
            checked++;
            if (expected_elems.size() == 0)
            begin
                $error("element word arrived with nothing expected");
                errors++;
                return;
            end
            want = expected_elems.pop_front();
            compare("column_index", want.column_index, got.column_index);
            compare("source_channel", want.source_channel, got.source_channel);
            compare("source_row", want.source_row, got.source_row);
            compare("source_col", want.source_col, got.source_col);
            compare("image_address", want.image_address, got.image_address);
            compare("is_padding", want.is_padding, got.is_padding);
            compare("last", want.last, got.last);
            compare("no_work", want.no_work, got.no_work);
        endfunction

        function int pending();
            return expected_elems.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2cag_cmd_if  cmd_ch();
    i2cag_elem_if elem_ch();

    im2col_walk_model model = new();
    bit steady_flow;
    int ticks_sent;
    int idle_cycles;

    im2col_address_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .elem      (elem_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // output side: random ready pattern plus one long hold-off,
    // started once the unit is full and the sender is waiting
    initial
    begin : elem_sink
        int seg_left;
        bit seg_rdy;
        bit held;
        elem_ch.ready = 1'b0;
        seg_left = 0;
        seg_rdy = 1'b0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && model.checked >= HOLD_AFTER && cmd_ch.valid && !cmd_ch.ready)
            begin
                held = 1'b1;
                elem_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (seg_left == 0)
            begin
                seg_rdy = ($urandom_range(0, 2) != 0);
                if (seg_rdy)
                    seg_left = $urandom_range(1, 30);
                else if ($urandom_range(0, 9) == 0)
                    seg_left = $urandom_range(10, 40);
                else
                    seg_left = $urandom_range(1, 3);
            end
            seg_left--;
            elem_ch.ready <= steady_flow || seg_rdy;
        end
    end

    always @(posedge clk)
    begin : elem_monitor
        elem_word_t got;
        if (rst_n && elem_ch.valid && elem_ch.ready)
        begin
            got.column_index   = elem_ch.column_index;
            got.source_channel = elem_ch.source_channel;
            got.source_row     = elem_ch.source_row;
            got.source_col     = elem_ch.source_col;
            got.image_address  = elem_ch.image_address;
            got.is_padding     = elem_ch.is_padding;
            got.last           = elem_ch.last;
            got.no_work        = elem_ch.no_work;
            model.check_element(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (cmd_ch.valid && cmd_ch.ready) ||
            (elem_ch.valid && elem_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_im2col_address_generator_unit: FAIL");
            $finish;
        end
    end

    // called at a falling edge; leaves the write enable high for a following write
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        logic [CFG_DATA_W-1:0] data_w;
        data_w = CFG_DATA_W'(data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data_w;
        @(posedge clk);
        model.write_reg(idx, data_w);
        @(negedge clk);
    endtask

    task automatic end_cfg();
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_ticks(input int n, input int restart_pct);
        int gap;
        int roll;
        for (int i = 0; i < n; i++)
        begin
            cmd_ch.valid   <= 1'b1;
            cmd_ch.restart <= ($urandom_range(0, 99) < restart_pct);
            do
                @(posedge clk);
            while (!cmd_ch.ready);
            model.note_tick(cmd_ch.restart);
            ticks_sent++;
            @(negedge clk);
            roll = $urandom_range(0, 99);
            if (steady_flow || roll < 55)
                gap = 0;
            else if (roll < 90)
                gap = $urandom_range(1, 3);
            else if (roll < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 40);
            if (gap > 0 || i == n - 1)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic drain();
        while (model.pending() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int kind;
        int unsigned ch_v, h_v, w_v, k_v, s_v, p_v;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_NUM_CHANNELS;
        cfg_data       = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.restart = 1'b0;
        steady_flow    = 1'b0;
        ticks_sent     = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: 1x1 image, every word is the last one
        send_ticks(2, 0);
        drain();

        // out-of-range values saturate; spare indexes do nothing
        write_cfg(REG_NUM_CHANNELS, 0);
        write_cfg(REG_IMAGE_HEIGHT, 0);
        write_cfg(REG_IMAGE_WIDTH, 11'h3FF);
        write_cfg(REG_KERNEL_SIZE, 0);
        write_cfg(REG_STEP_SIZE, 15);
        write_cfg(REG_BORDER_PAD, 3);
        write_cfg(CFG_IDX_SPARE_LO, 11'h7FF);
        write_cfg(CFG_IDX_SPARE_HI, 5);
        end_cfg();
        send_ticks(2, 0);
        send_ticks(1, 100);
        drain();

        // kernel wider than the padded image
        write_cfg(REG_IMAGE_HEIGHT, 2);
        write_cfg(REG_IMAGE_WIDTH, 2);
        write_cfg(REG_KERNEL_SIZE, 7);
        write_cfg(REG_BORDER_PAD, 0);
        write_cfg(REG_NUM_CHANNELS, 11'h7FF);
        end_cfg();
        send_ticks(1, 0);
        send_ticks(1, 100);
        drain();

        // four-element walk, wraps after the last word
        write_cfg(REG_NUM_CHANNELS, 1);
        write_cfg(REG_KERNEL_SIZE, 2);
        write_cfg(REG_STEP_SIZE, 1);
        end_cfg();
        send_ticks(5, 0);
        drain();

        // every register at its top value
        write_cfg(REG_NUM_CHANNELS, MAX_CHANNELS);
        write_cfg(REG_IMAGE_HEIGHT, MAX_SIDE);
        write_cfg(REG_IMAGE_WIDTH, MAX_SIDE);
        write_cfg(REG_KERNEL_SIZE, MAX_KERNEL);
        write_cfg(REG_STEP_SIZE, STEP_LIMIT);
        write_cfg(REG_BORDER_PAD, 3);
        end_cfg();
        send_ticks(3, 0);
        send_ticks(1, 100);
        send_ticks(2, 0);

        ticks_sent = 0;
        while (ticks_sent < RANDOM_TICKS)
        begin
            drain();
            steady_flow = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                // small images so walks finish and wrap often
                ch_v = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
                h_v  = $urandom_range(1, 8);
                w_v  = $urandom_range(1, 8);
                k_v  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : $urandom_range(1, 3);
                s_v  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2);
                p_v  = $urandom_range(0, 3);
            end
            else if (kind == 7)
            begin
                ch_v = $urandom_range(0, 2047);
                h_v  = $urandom_range(0, 2047);
                w_v  = $urandom_range(0, 2047);
                k_v  = $urandom_range(0, 2047);
                s_v  = $urandom_range(0, 2047);
                p_v  = $urandom_range(0, 2047);
            end
            else
            begin
                ch_v = ($urandom_range(0, 1) == 0) ? MAX_CHANNELS : $urandom_range(512, 1024);
                h_v  = ($urandom_range(0, 1) == 0) ? MAX_SIDE : $urandom_range(1, 512);
                w_v  = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(1, 512);
                k_v  = $urandom_range(1, 7);
                s_v  = $urandom_range(1, 8);
                p_v  = $urandom_range(0, 3);
            end
            if ($urandom_range(0, 3) != 0)
                write_cfg(REG_NUM_CHANNELS, ch_v);
            if ($urandom_range(0, 3) != 0)
                write_cfg(REG_IMAGE_HEIGHT, h_v);
            if ($urandom_range(0, 3) != 0)
                write_cfg(REG_IMAGE_WIDTH, w_v);
            if ($urandom_range(0, 3) != 0)
                write_cfg(REG_KERNEL_SIZE, k_v);
            if ($urandom_range(0, 3) != 0)
                write_cfg(REG_STEP_SIZE, s_v);
            if ($urandom_range(0, 3) != 0)
                write_cfg(REG_BORDER_PAD, p_v);
            if ($urandom_range(0, 7) == 0)
                write_cfg(($urandom_range(0, 1) == 0) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                          $urandom_range(0, 2047));
            end_cfg();
            send_ticks((kind < 8) ? $urandom_range(20, 120) : $urandom_range(30, 80),
                       $urandom_range(0, 4));
        end

        steady_flow = 1'b0;
        while (model.pending() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (model.errors == 0 && model.pending() == 0)
            $display("tb_im2col_address_generator_unit: PASS");
        else
            $display("tb_im2col_address_generator_unit: FAIL");
        $finish;
    end

endmodule
